// ===== rtl/gha_pkg.sv =====
// Shared constants and types of the generational handle allocator.
package gha_pkg;

  localparam int SLOTS  = 1024;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int IDX_W  = SLOT_W + 1;
  localparam int GEN_W  = 32;
  localparam int DOM_W  = 16;
  localparam int REV_W  = 64;

  // Free-list head value that means the list is empty.
  localparam logic [IDX_W-1:0] NO_SLOT   = IDX_W'(SLOTS);
  localparam logic [GEN_W-1:0] GEN_START = GEN_W'(1);

  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_LOOKUP  = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_STALE = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic             alive;
    logic [GEN_W-1:0] generation;
    logic [IDX_W-1:0] next_free;
  } slot_entry_t;

  function automatic logic [GEN_W-1:0] bump_generation(input logic [GEN_W-1:0] g);
    logic [GEN_W-1:0] n;
    n = g + GEN_W'(1);
    return (n == '0) ? GEN_START : n;
  endfunction

endpackage

// ===== rtl/generational_handle_allocator.sv =====
// Generational handle allocator: top level with request sequencing and result register.
//
// Requests enter on the s_ stream: tuser carries the command (allocate, release,
// look up) and tdata the presented handle. Every request yields exactly one
// result item on the m_ stream: tuser carries the status, tdata the allocated
// handle (index and generation, zero unless an allocate succeeded) and the
// revision counter after the request.
// Each request is a read-modify-write of its slot entry: the entry is read from
// the slot memory when the request is taken, then checked, written back and the
// result register loaded. A new request is not taken until the current one has
// loaded the result register; m_tvalid rises when that register is loaded.
// A new request is taken while an earlier result still waits in the result
// register; if the receiver stalls, the second request holds in its check
// cycle until the register frees up, and the input then stalls in turn.
// Reset (rst, synchronous) empties the free list, zeroes the used-slot count
// and the revision counter and sets the domain register to 1. No clearing
// pass is needed: slots at or above the used count are never trusted.
// cfg_wen/cfg_wdata write the domain register; write it only while idle.
module generational_handle_allocator (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wen,
  input  logic [15:0]  cfg_wdata,   // world_domain
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,     // handle_domain[15:0], handle_index[26:16],
                                    // handle_generation[58:27], zero pad
  input  logic [1:0]   s_tuser,     // command
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [111:0] m_tdata,     // result_index[10:0], result_generation[42:11],
                                    // revision_count[106:43], zero pad
  output logic [1:0]   m_tuser      // status
);
  import gha_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic             state;
  logic [DOM_W-1:0] world_domain;
  logic [IDX_W-1:0] free_list_head;
  logic [IDX_W-1:0] slots_used;
  logic [REV_W-1:0] revision;

  logic [1:0]       cmd_q;
  logic [DOM_W-1:0] dom_q;
  logic [IDX_W-1:0] idx_q;
  logic [GEN_W-1:0] gen_q;

  logic [1:0]       out_status;
  logic [IDX_W-1:0] out_index;
  logic [GEN_W-1:0] out_gen;
  logic [REV_W-1:0] out_rev;

  logic             in_accept;
  logic             out_load;
  logic [IDX_W-1:0] in_slot;
  logic [SLOT_W-1:0] rd_addr;
  slot_entry_t      rd_data;
  logic             wr_en;
  logic [SLOT_W-1:0] wr_addr;
  slot_entry_t      wr_data;

  logic [IDX_W-1:0] slot_q;
  logic             handle_ok;
  logic             head_valid;
  logic [1:0]       status_next;
  logic [IDX_W-1:0] index_next;
  logic [GEN_W-1:0] gen_next;
  logic             rev_inc;
  logic [IDX_W-1:0] head_next;
  logic [IDX_W-1:0] used_next;

  assign s_tready  = (state == ST_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign out_load  = (state == ST_EXEC) && (!m_tvalid || m_tready);

  // Read address: the free-list head for an allocate, the presented slot otherwise.
  assign in_slot = s_tdata[26:16] - IDX_W'(1);
  assign rd_addr = (s_tuser == CMD_ALLOC) ? free_list_head[SLOT_W-1:0]
                                          : in_slot[SLOT_W-1:0];

  gha_slot_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (in_accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign slot_q     = idx_q - IDX_W'(1);
  assign head_valid = (free_list_head < NO_SLOT);
  assign handle_ok  = (dom_q == world_domain) && (idx_q != '0) && (slot_q < slots_used)
                      && rd_data.alive && (rd_data.generation == gen_q);

  always_comb begin
    status_next = STAT_STALE;
    index_next  = '0;
    gen_next    = '0;
    rev_inc     = 1'b0;
    head_next   = free_list_head;
    used_next   = slots_used;
    wr_en       = 1'b0;
    wr_addr     = slot_q[SLOT_W-1:0];
    wr_data     = rd_data;
    case (cmd_q)
      CMD_ALLOC: begin
        if (head_valid) begin
          status_next     = STAT_OK;
          index_next      = free_list_head + IDX_W'(1);
          gen_next        = rd_data.generation;
          rev_inc         = 1'b1;
          head_next       = rd_data.next_free;
          wr_en           = out_load;
          wr_addr         = free_list_head[SLOT_W-1:0];
          wr_data.alive   = 1'b1;
        end else if (slots_used < NO_SLOT) begin
          status_next        = STAT_OK;
          index_next         = slots_used + IDX_W'(1);
          gen_next           = GEN_START;
          rev_inc            = 1'b1;
          used_next          = slots_used + IDX_W'(1);
          wr_en              = out_load;
          wr_addr            = slots_used[SLOT_W-1:0];
          wr_data.alive      = 1'b1;
          wr_data.generation = GEN_START;
        end else begin
          status_next = STAT_FULL;
        end
      end
      CMD_RELEASE: begin
        if (handle_ok) begin
          status_next        = STAT_OK;
          rev_inc            = 1'b1;
          head_next          = slot_q;
          wr_en              = out_load;
          wr_data.alive      = 1'b0;
          wr_data.generation = bump_generation(rd_data.generation);
          wr_data.next_free  = free_list_head;
        end
      end
      CMD_LOOKUP: begin
        if (handle_ok) begin
          status_next = STAT_OK;
        end
      end
      default: begin
        status_next = STAT_STALE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      world_domain   <= DOM_W'(1);
      free_list_head <= NO_SLOT;
      slots_used     <= '0;
      revision       <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (cfg_wen) begin
        world_domain <= cfg_wdata;
      end
      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (out_load) begin
            state          <= ST_IDLE;
            m_tvalid       <= 1'b1;
            free_list_head <= head_next;
            slots_used     <= used_next;
            if (rev_inc) begin
              revision <= revision + REV_W'(1);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_q <= s_tuser;
      dom_q <= s_tdata[15:0];
      idx_q <= s_tdata[26:16];
      gen_q <= s_tdata[58:27];
    end
    if (out_load) begin
      out_status <= status_next;
      out_index  <= index_next;
      out_gen    <= gen_next;
      out_rev    <= rev_inc ? revision + REV_W'(1) : revision;
    end
  end

  assign m_tuser = out_status;
  assign m_tdata = {5'b0, out_rev, out_gen, out_index};

`ifndef SYNTHESIS
  a_bounds: assert property (@(posedge clk) disable iff (rst)
    slots_used <= NO_SLOT && free_list_head <= NO_SLOT)
    else $error("slot count or free-list head out of range");

  a_rev_step: assert property (@(posedge clk) disable iff (rst)
    out_load |=> revision == $past(revision) || revision == $past(revision) + REV_W'(1))
    else $error("revision moved by more than one");

  a_rev_only_on_load: assert property (@(posedge clk) disable iff (rst)
    !out_load |=> $stable(revision))
    else $error("revision changed without a result");

  a_alloc_handle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_index != '0 |-> out_status == STAT_OK && out_gen != '0)
    else $error("allocated handle with zero generation or bad status");
`endif

endmodule

// ===== rtl/gha_slot_ram.sv =====
// Slot table memory: one write port, one read port with registered read data.
module gha_slot_ram (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [gha_pkg::SLOT_W-1:0] wr_addr,
  input  gha_pkg::slot_entry_t    wr_data,
  input  logic                    rd_en,
  input  logic [gha_pkg::SLOT_W-1:0] rd_addr,
  output gha_pkg::slot_entry_t    rd_data
);
  import gha_pkg::*;

  slot_entry_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the generational handle allocator.
`timescale 1ns / 100ps

module tb_top;
  import gha_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int LONG_HOLD = 80;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [DOM_W-1:0] dom;
    logic [IDX_W-1:0] idx;
    logic [GEN_W-1:0] gen;
  } request_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] index;
    logic [GEN_W-1:0] gen;
    logic [REV_W-1:0] rev;
  } answer_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [GEN_W-1:0] gen;
  } handle_t;

  typedef struct {
    request_t req;
    bit       typed;
    answer_t  ans;
  } script_row_t;

  logic         clk;
  logic         rst = 1'b1;
  logic         cfg_wen = 1'b0;
  logic [15:0]  cfg_wdata = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [63:0]  s_tdata = '0;    // handle_domain[15:0], handle_index[26:16],
                                 // handle_generation[58:27], zero pad
  logic [1:0]   s_tuser = '0;    // command
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [111:0] m_tdata;         // result_index[10:0], result_generation[42:11],
                                 // revision_count[106:43], zero pad
  logic [1:0]   m_tuser;         // status

  generational_handle_allocator DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Own copy of the handle table
  logic             slot_live [SLOTS];
  logic [GEN_W-1:0] slot_gen  [SLOTS];
  logic [IDX_W-1:0] slot_link [SLOTS];
  logic [IDX_W-1:0] free_top;
  logic [IDX_W-1:0] fresh_count;
  logic [REV_W-1:0] rev_count;
  logic [DOM_W-1:0] cur_domain;

  handle_t     live_handles[$];
  handle_t     retired_handles[$];
  answer_t     answers_due[$];
  script_row_t opening_rows[$];

  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  bit hold_req  = 1'b0;

  int requests_sent   = 0;
  int answers_checked = 0;
  int full_refusals   = 0;
  int stale_answers   = 0;
  int domains_written = 0;
  int mismatches      = 0;

  function automatic answer_t handle_table_step(request_t r);
    answer_t a;
    int      s;
    int      pos;
    logic    hit;
    a = '{status: STAT_STALE, index: '0, gen: '0, rev: '0};
    s = int'(r.idx) - 1;
    pos = -1;
    hit = (r.dom == cur_domain) && (r.idx != '0) && (s < int'(fresh_count))
          && slot_live[s] && (slot_gen[s] == r.gen);
    case (r.cmd)
      CMD_ALLOC: begin
        if (free_top < NO_SLOT) begin
          s = int'(free_top);
          free_top = slot_link[s];
        end else if (fresh_count != IDX_W'(SLOTS)) begin
          s = int'(fresh_count);
          fresh_count = fresh_count + 1'b1;
          slot_gen[s] = GEN_START;
        end else begin
          s = -1;
        end
        if (s >= 0) begin
          slot_live[s] = 1'b1;
          rev_count = rev_count + 1'b1;
          a.status = STAT_OK;
          a.index = IDX_W'(s + 1);
          a.gen = slot_gen[s];
          live_handles.push_back('{idx: a.index, gen: a.gen});
        end else begin
          a.status = STAT_FULL;
        end
      end
      CMD_RELEASE, CMD_LOOKUP: begin
        if (hit) begin
          a.status = STAT_OK;
          if (r.cmd == CMD_RELEASE) begin
            slot_live[s] = 1'b0;
            // generation zero is never handed out
            slot_gen[s] = (slot_gen[s] == '1) ? GEN_START : slot_gen[s] + 1'b1;
            slot_link[s] = free_top;
            free_top = IDX_W'(s);
            rev_count = rev_count + 1'b1;
            for (int k = 0; k < live_handles.size(); k++)
              if (live_handles[k].idx == r.idx) pos = k;
            if (pos >= 0) live_handles.delete(pos);
            retired_handles.push_back('{idx: r.idx, gen: r.gen});
            if (retired_handles.size() > 64) retired_handles.delete(0);
          end
        end
      end
      default: ;
    endcase
    a.rev = rev_count;
    return a;
  endfunction

  // Mostly well-formed handles from the live set, some stale or corrupted, some noise
  function automatic request_t random_request();
    request_t r;
    handle_t  h;
    int       pick;
    pick = $urandom_range(0, 99);
    r.cmd = CMD_ALLOC;
    r.dom = DOM_W'($urandom);
    r.idx = IDX_W'($urandom);
    r.gen = $urandom;
    if (pick < 35 || live_handles.size() == 0) return r;
    if (pick >= 90) begin
      r.cmd = 2'($urandom_range(0, 3));
      return r;
    end
    if (pick >= 80 && pick < 85 && retired_handles.size() > 0)
      h = retired_handles[$urandom_range(0, retired_handles.size() - 1)];
    else
      h = live_handles[$urandom_range(0, live_handles.size() - 1)];
    if (pick < 60) r.cmd = CMD_RELEASE;
    else if (pick < 80) r.cmd = CMD_LOOKUP;
    else r.cmd = $urandom_range(0, 1) ? CMD_RELEASE : CMD_LOOKUP;
    r.dom = cur_domain;
    r.idx = h.idx;
    r.gen = h.gen;
    if (pick >= 85) begin
      case ($urandom_range(0, 2))
        0: r.dom = r.dom ^ (DOM_W'(1) << $urandom_range(0, DOM_W - 1));
        1: r.gen = r.gen ^ (GEN_W'(1) << $urandom_range(0, GEN_W - 1));
        default: r.idx = r.idx ^ (IDX_W'(1) << $urandom_range(0, IDX_W - 1));
      endcase
    end
    return r;
  endfunction

  task automatic offer_request(input request_t r, input bit typed, input answer_t typed_ans,
                               output answer_t predicted);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= r.cmd;
    s_tdata  <= {5'b0, r.gen, r.idx, r.dom};
    do @(posedge clk); while (!s_tready);
    predicted = handle_table_step(r);
    answers_due.push_back(typed ? typed_ans : predicted);
    requests_sent++;
    if (predicted.status == STAT_FULL) full_refusals++;
    if (predicted.status == STAT_STALE) stale_answers++;
  endtask

  task automatic wait_for_answers();
    s_tvalid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_world_domain(input logic [DOM_W-1:0] value);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    cur_domain = value;
    domains_written++;
  endtask

  task automatic random_phase(input int count, input bit with_pressure);
    answer_t ans;
    for (int i = 0; i < count; i++) begin
      if (with_pressure && i == 0) begin
        // stall the output long enough to back up the input
        hold_req = 1'b1;
        tx_steady = 1'b1;
      end else if (with_pressure && i == count / 2) begin
        wait_for_answers();
      end else if (i % 40 == 0) begin
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
      end
      offer_request(random_request(), 1'b0, '0, ans);
    end
  endtask

  task automatic add_row(input logic [1:0] cmd, input logic [DOM_W-1:0] dom,
                         input logic [IDX_W-1:0] idx, input logic [GEN_W-1:0] gen,
                         input bit typed, input logic [1:0] st,
                         input logic [IDX_W-1:0] ri, input logic [GEN_W-1:0] rg,
                         input logic [REV_W-1:0] rv);
    script_row_t row;
    row.req = '{cmd: cmd, dom: dom, idx: idx, gen: gen};
    row.typed = typed;
    row.ans = '{status: st, index: ri, gen: rg, rev: rv};
    opening_rows.push_back(row);
  endtask

  // Receiver: random stalls per item, one long hold on request
  initial begin : result_sink
    int n;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        hold_req = 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      n = rx_steady ? 0 : $urandom_range(0, 11);
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  always @(posedge clk) begin : answer_check
    answer_t want;
    answer_t seen;
    if (!rst && m_tvalid && m_tready) begin
      seen = '{status: m_tuser, index: m_tdata[10:0], gen: m_tdata[42:11],
               rev: m_tdata[106:43]};
      if (answers_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: status %0d index %0d gen %0h rev %0d",
                   seen.status, seen.index, seen.gen, seen.rev);
      end else begin
        want = answers_due.pop_front();
        if (seen.status != want.status || seen.index != want.index ||
            seen.gen != want.gen || seen.rev != want.rev) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch on item %0d: status %0d/%0d index %0d/%0d",
                      " gen %0h/%0h rev %0d/%0d (exp/got)"},
                     answers_checked, want.status, seen.status, want.index, seen.index,
                     want.gen, seen.gen, want.rev, seen.rev);
        end
        answers_checked++;
      end
    end
  end

  initial begin : run_limit
    #10_000_000;
    $display("FAIL generational_handle_allocator");
    $finish;
  end

  initial begin : stimulus
    answer_t ans;
    for (int k = 0; k < SLOTS; k++) begin
      slot_live[k] = 1'b0;
      slot_gen[k]  = '0;
      slot_link[k] = '0;
    end
    free_top    = NO_SLOT;
    fresh_count = '0;
    rev_count   = '0;
    cur_domain  = 16'd1;

    // cmd, dom, idx, gen, typed, status, index, gen, revision
    add_row(CMD_LOOKUP,  16'd1,      11'd1,    32'd1,        1, STAT_STALE, 0, 0, 0);
    add_row(CMD_RELEASE, 16'd1,      11'd0,    32'd0,        1, STAT_STALE, 0, 0, 0);
    add_row(CMD_ALLOC,   16'd0,      11'd0,    32'd0,        1, STAT_OK,    1, 1, 1);
    add_row(CMD_ALLOC,   16'd0,      11'd0,    32'd0,        1, STAT_OK,    2, 1, 2);
    add_row(CMD_LOOKUP,  16'd1,      11'd1,    32'd1,        1, STAT_OK,    0, 0, 2);
    add_row(CMD_LOOKUP,  16'd0,      11'd1,    32'd1,        1, STAT_STALE, 0, 0, 2);
    add_row(CMD_LOOKUP,  16'd1,      11'd3,    32'd1,        1, STAT_STALE, 0, 0, 2);
    add_row(CMD_LOOKUP,  16'd1,      11'd1,    32'd2,        1, STAT_STALE, 0, 0, 2);
    add_row(CMD_LOOKUP,  16'hFFFF,   11'd2047, 32'hFFFFFFFF, 1, STAT_STALE, 0, 0, 2);
    add_row(CMD_RELEASE, 16'd1,      11'd1,    32'd1,        1, STAT_OK,    0, 0, 3);
    add_row(CMD_LOOKUP,  16'd1,      11'd1,    32'd1,        1, STAT_STALE, 0, 0, 3);
    add_row(CMD_RELEASE, 16'd1,      11'd1,    32'd1,        1, STAT_STALE, 0, 0, 3);
    add_row(CMD_LOOKUP,  16'd1,      11'd1,    32'd2,        1, STAT_STALE, 0, 0, 3);
    add_row(CMD_RELEASE, 16'd1,      11'd2,    32'd1,        1, STAT_OK,    0, 0, 4);
    // reuse order off the free list
    add_row(CMD_ALLOC,   16'd0,      11'd0,    32'd0,        0, STAT_OK,    0, 0, 0);
    add_row(CMD_ALLOC,   16'd0,      11'd0,    32'd0,        0, STAT_OK,    0, 0, 0);
    add_row(CMD_ALLOC,   16'd0,      11'd0,    32'd0,        1, STAT_OK,    3, 1, 7);
    add_row(CMD_UNUSED,  16'd1,      11'd1,    32'd2,        1, STAT_STALE, 0, 0, 7);
    add_row(CMD_LOOKUP,  16'd1,      11'd1,    32'd2,        0, STAT_OK,    0, 0, 0);
    add_row(CMD_LOOKUP,  16'd1,      11'd0,    32'd0,        1, STAT_STALE, 0, 0, 7);
    add_row(CMD_RELEASE, 16'd1,      11'd1025, 32'd0,        1, STAT_STALE, 0, 0, 7);
    add_row(CMD_LOOKUP,  16'd1,      11'd1024, 32'd1,        1, STAT_STALE, 0, 0, 7);
    add_row(CMD_ALLOC,   16'hFFFF,   11'd2047, 32'hFFFFFFFF, 1, STAT_OK,    4, 1, 8);
    add_row(CMD_RELEASE, 16'd0,      11'd4,    32'd1,        1, STAT_STALE, 0, 0, 8);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (opening_rows[i])
      offer_request(opening_rows[i].req, opening_rows[i].typed, opening_rows[i].ans, ans);

    wait_for_answers();
    set_world_domain(16'h0000);
    random_phase(200, 1'b0);
    wait_for_answers();
    set_world_domain(16'hFFFF);
    random_phase(200, 1'b0);
    wait_for_answers();
    set_world_domain(DOM_W'($urandom_range(2, 65534)));
    random_phase(220, 1'b1);
    wait_for_answers();

    // Back to the reset domain for a last mixed burst
    set_world_domain(16'd1);
    tx_steady = 1'b0;
    repeat (4) offer_request('{cmd: CMD_ALLOC, dom: '0, idx: '0, gen: '0}, 1'b0, '0, ans);
    repeat (10) offer_request(random_request(), 1'b0, '0, ans);

    wait_for_answers();
    repeat (8) @(posedge clk);
    $display("%0d requests, %0d answers checked: %0d refused as full, %0d stale or bad",
             requests_sent, answers_checked, full_refusals, stale_answers);
    $display("%0d domain settings written, %0d mismatches", domains_written, mismatches);
    if (mismatches == 0 && answers_due.size() == 0) begin
      $display("PASS generational_handle_allocator");
    end else begin
      $display("FAIL generational_handle_allocator");
    end
    $finish;
  end

endmodule
